@@ design/sllt_pkg.sv @@
// Package for the sorted linked list table: sizes, codes, states and store write struct.
`timescale 1ns / 1ps
package sllt_pkg;

   localparam int SLOTS  = 64;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int PTR_W  = $clog2(SLOTS + 1);
   localparam int KEY_W  = 32;
   localparam int CMD_W  = 2;

   localparam logic [PTR_W-1:0] NONE_PTR = PTR_W'(SLOTS);

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK_RD,
      ST_WALK,
      ST_DECIDE,
      ST_INS_FREE,
      ST_INS_LINK,
      ST_DEL_FREE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              clear;
      logic              key_we;
      logic [SLOT_W-1:0] key_addr;
      logic [KEY_W-1:0]  key_data;
      logic              link_we;
      logic [SLOT_W-1:0] link_addr;
      logic [PTR_W-1:0]  link_data;
   } store_wr_type;

endpackage

@@ design/sllt_if.sv @@
// Request and response channel interfaces of the sorted linked list table.
`timescale 1ns / 1ps
interface sllt_req_if;
   import sllt_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic signed [KEY_W-1:0] key;
   modport source (output valid, output cmd, output key, input ready);
   modport sink (input valid, input cmd, input key, output ready);
endinterface

interface sllt_rsp_if;
   import sllt_pkg::*;
   logic              valid;
   logic              ready;
   logic              ok;
   logic [SLOT_W-1:0] slot;
   logic [PTR_W-1:0]  count;
   modport source (output valid, output ok, output slot, output count, input ready);
   modport sink (input valid, input ok, input slot, input count, output ready);
endinterface

@@ design/sorted_linked_list_table_core.sv @@
// Sorted linked list table: command sequencer, list walk and result register.
//
// Usage: each word on req_chan carries a command (insert, delete, search,
// clear) and a signed 32-bit key. Each accepted word gives exactly one word
// on rsp_chan with ok, the slot used, freed or found, and the key count.
// req_chan.ready is high only while the sequencer is idle; one command is
// worked on at a time. The walk reads one list entry per cycle through the
// single read port of the key and link memories and one key compare.
// Clear goes straight to the result; search and failed commands pass the
// walk read, walk and decide states, a delete adds a free-list step and an
// insert a free-slot read and a link step. The walk passes the keys below
// the given key (at most 64); the sequencer returns to idle before the next accept.
// A finished word waits in the rsp register; a new command is accepted
// while it waits, but the next result is held back until it is taken.
// Reset (synchronous) empties the list, chains all slots into the free
// list and clears rsp valid; no clearing pass is needed.
`timescale 1ns / 1ps
module sorted_linked_list_table_core (
   input logic        clock,
   input logic        reset,
   sllt_req_if.sink   req_chan,
   sllt_rsp_if.source rsp_chan
);
   import sllt_pkg::*;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [PTR_W-1:0]  cur_ff, cur_in;
   logic [PTR_W-1:0]  prev_ff, prev_in;
   logic [PTR_W-1:0]  raw_ff, raw_in;
   logic [PTR_W-1:0]  cur_link_ff, cur_link_in;
   logic [PTR_W-1:0]  steps_ff, steps_in;
   logic              found_ff, found_in;
   logic [PTR_W-1:0]  list_head_ff, list_head_in;
   logic [PTR_W-1:0]  free_head_ff, free_head_in;
   logic [PTR_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] new_ff, new_in;
   logic              res_ok_ff, res_ok_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [PTR_W-1:0]  rsp_count_ff, rsp_count_in;

   store_wr_type      wr;
   logic [SLOT_W-1:0] rd_addr;
   logic [KEY_W-1:0]  key_rd;
   logic [PTR_W-1:0]  link_rd;
   logic              cur_is_slot;
   logic              key_less;
   logic              walk_more;

   sllt_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_addr (rd_addr),
      .key_rd  (key_rd),
      .link_rd (link_rd)
   );

   assign cur_is_slot = (cur_ff < NONE_PTR);
   assign key_less    = ($signed(key_rd) < $signed(key_ff));
   assign walk_more   = cur_is_slot && key_less && (steps_ff < NONE_PTR);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      raw_in       = raw_ff;
      cur_link_in  = cur_link_ff;
      steps_in     = steps_ff;
      found_in     = found_ff;
      list_head_in = list_head_ff;
      free_head_in = free_head_ff;
      count_in     = count_ff;
      new_in       = new_ff;
      res_ok_in    = res_ok_ff;
      res_slot_in  = res_slot_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rd_addr      = cur_ff[SLOT_W-1:0];
      wr           = '0;
      req_chan.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               cmd_in      = cmd_type'(req_chan.cmd);
               key_in      = req_chan.key;
               res_ok_in   = 1'b0;
               res_slot_in = '0;
               if (cmd_type'(req_chan.cmd) == CMD_CLEAR) begin
                  wr.clear     = 1'b1;
                  list_head_in = NONE_PTR;
                  free_head_in = '0;
                  count_in     = '0;
                  res_ok_in    = 1'b1;
                  state_in     = ST_DONE;
               end else begin
                  cur_in   = list_head_ff;
                  prev_in  = NONE_PTR;
                  steps_in = '0;
                  state_in = ST_WALK_RD;
               end
            end
         end
         ST_WALK_RD: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (walk_more) begin
               prev_in  = cur_ff;
               cur_in   = link_rd;
               steps_in = steps_ff + PTR_W'(1);
               rd_addr  = link_rd[SLOT_W-1:0];
            end else begin
               raw_in      = cur_ff;
               cur_link_in = link_rd;
               found_in    = cur_is_slot && (steps_ff < NONE_PTR) && (key_rd == key_ff);
               if (!cur_is_slot || steps_ff >= NONE_PTR) begin
                  cur_in = NONE_PTR;
               end
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_DONE;
            case (cmd_ff)
               CMD_INSERT: begin
                  if (!found_ff && free_head_ff < NONE_PTR) begin
                     rd_addr  = free_head_ff[SLOT_W-1:0];
                     new_in   = free_head_ff[SLOT_W-1:0];
                     state_in = ST_INS_FREE;
                  end
               end
               CMD_DELETE: begin
                  if (found_ff) begin
                     if (prev_ff < NONE_PTR) begin
                        wr.link_we   = 1'b1;
                        wr.link_addr = prev_ff[SLOT_W-1:0];
                        wr.link_data = cur_link_ff;
                     end else begin
                        list_head_in = cur_link_ff;
                     end
                     state_in = ST_DEL_FREE;
                  end
               end
               CMD_SEARCH: begin
                  if (found_ff) begin
                     res_ok_in   = 1'b1;
                     res_slot_in = cur_ff[SLOT_W-1:0];
                  end
               end
               default: begin
               end
            endcase
         end
         ST_INS_FREE: begin
            free_head_in = link_rd;
            wr.key_we    = 1'b1;
            wr.key_addr  = new_ff;
            wr.key_data  = key_ff;
            wr.link_we   = 1'b1;
            wr.link_addr = new_ff;
            wr.link_data = raw_ff;
            state_in     = ST_INS_LINK;
         end
         ST_INS_LINK: begin
            if (prev_ff < NONE_PTR) begin
               wr.link_we   = 1'b1;
               wr.link_addr = prev_ff[SLOT_W-1:0];
               wr.link_data = PTR_W'(new_ff);
            end else begin
               list_head_in = PTR_W'(new_ff);
            end
            count_in    = count_ff + PTR_W'(1);
            res_ok_in   = 1'b1;
            res_slot_in = new_ff;
            state_in    = ST_DONE;
         end
         ST_DEL_FREE: begin
            wr.link_we   = 1'b1;
            wr.link_addr = cur_ff[SLOT_W-1:0];
            wr.link_data = free_head_ff;
            free_head_in = cur_ff;
            if (count_ff != '0) begin
               count_in = count_ff - PTR_W'(1);
            end
            res_ok_in   = 1'b1;
            res_slot_in = cur_ff[SLOT_W-1:0];
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_slot_in  = res_slot_ff;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         list_head_ff <= NONE_PTR;
         free_head_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      raw_ff       <= raw_in;
      cur_link_ff  <= cur_link_in;
      steps_ff     <= steps_in;
      found_ff     <= found_in;
      new_ff       <= new_in;
      res_ok_ff    <= res_ok_in;
      res_slot_ff  <= res_slot_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.ok    = rsp_ok_ff;
   assign rsp_chan.slot  = rsp_slot_ff;
   assign rsp_chan.count = rsp_count_ff;

endmodule

@@ design/sllt_store.sv @@
// Key and link memories with per-slot link valid bits; unwritten links read as slot+1.
`timescale 1ns / 1ps
module sllt_store (
   input  logic                         clock,
   input  logic                         reset,
   input  sllt_pkg::store_wr_type       wr,
   input  logic [sllt_pkg::SLOT_W-1:0]  rd_addr,
   output logic [sllt_pkg::KEY_W-1:0]   key_rd,
   output logic [sllt_pkg::PTR_W-1:0]   link_rd
);
   import sllt_pkg::*;

   logic [KEY_W-1:0]  key_mem [SLOTS];
   logic [PTR_W-1:0]  link_mem [SLOTS];
   logic [SLOTS-1:0]  valid_ff;
   logic [SLOTS-1:0]  valid_in;
   logic [KEY_W-1:0]  key_rd_ff;
   logic [PTR_W-1:0]  link_rd_ff;
   logic              valid_rd_ff;
   logic [SLOT_W-1:0] addr_rd_ff;

   always_ff @(posedge clock) begin
      if (wr.key_we) begin
         key_mem[wr.key_addr] <= wr.key_data;
      end
      key_rd_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.link_we) begin
         link_mem[wr.link_addr] <= wr.link_data;
      end
      link_rd_ff <= link_mem[rd_addr];
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr.clear) begin
         valid_in = '0;
      end else if (wr.link_we) begin
         valid_in[wr.link_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      valid_rd_ff <= valid_ff[rd_addr];
      addr_rd_ff  <= rd_addr;
   end

   // the reset chain ends at the last slot with the none marker
   assign key_rd  = key_rd_ff;
   assign link_rd = valid_rd_ff ? link_rd_ff : PTR_W'(addr_rd_ff) + PTR_W'(1);

endmodule

@@ tb/sv/sllt_checker.sv @@
// Checker for the sorted linked list table: mirrors the list and compares every rsp word.
`timescale 1ns / 1ps
module sllt_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [sllt_pkg::CMD_W-1:0]        req_cmd,
   input  logic signed [sllt_pkg::KEY_W-1:0] req_key,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_ok,
   input  logic [sllt_pkg::SLOT_W-1:0]       rsp_slot,
   input  logic [sllt_pkg::PTR_W-1:0]        rsp_count,
   output int unsigned                       fail_count,
   output int unsigned                       pending_count
);
   import sllt_pkg::*;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [KEY_W-1:0]  key;
      logic              ok;
      logic [SLOT_W-1:0] slot;
      logic [PTR_W-1:0]  count;
   } table_rsp_type;

   logic signed [KEY_W-1:0] mirror_keys [SLOTS];
   logic [PTR_W-1:0]        mirror_links [SLOTS];
   logic [PTR_W-1:0]        mirror_head;
   logic [PTR_W-1:0]        mirror_free;
   logic [PTR_W-1:0]        mirror_count;
   table_rsp_type           predicted_rsps [$];

   function automatic void rebuild_free_list();
      for (int i = 0; i < SLOTS - 1; i++) begin
         mirror_links[i] = PTR_W'(i + 1);
      end
      mirror_links[SLOTS-1] = NONE_PTR;
      mirror_head  = NONE_PTR;
      mirror_free  = '0;
      mirror_count = '0;
   endfunction

   function automatic table_rsp_type apply_command(input logic [CMD_W-1:0]        cmd,
                                                   input logic signed [KEY_W-1:0] key);
      table_rsp_type    r;
      logic [PTR_W-1:0] prev;
      logic [PTR_W-1:0] cur;
      logic [PTR_W-1:0] n;
      int               steps;
      logic             found;
      r     = '0;
      r.cmd = cmd;
      r.key = key;
      if (cmd == CMD_CLEAR) begin
         rebuild_free_list();
         r.ok = 1'b1;
      end else begin
         // walk to the first key not below the given one
         prev  = NONE_PTR;
         cur   = mirror_head;
         steps = 0;
         while (cur < SLOTS && mirror_keys[cur] < key && steps < SLOTS) begin
            prev = cur;
            cur  = mirror_links[cur];
            steps++;
         end
         if (!(cur < SLOTS) || steps >= SLOTS) cur = NONE_PTR;
         found = (cur < SLOTS) && (mirror_keys[cur] == key);
         case (cmd_type'(cmd))
            CMD_INSERT: begin
               if (!found && mirror_free < SLOTS) begin
                  n              = mirror_free;
                  mirror_free    = mirror_links[n];
                  mirror_keys[n] = key;
                  if (prev < SLOTS) begin
                     mirror_links[n]    = mirror_links[prev];
                     mirror_links[prev] = n;
                  end else begin
                     mirror_links[n] = mirror_head;
                     mirror_head     = n;
                  end
                  mirror_count++;
                  r.ok   = 1'b1;
                  r.slot = n[SLOT_W-1:0];
               end
            end
            CMD_DELETE: begin
               if (found) begin
                  if (prev < SLOTS) mirror_links[prev] = mirror_links[cur];
                  else mirror_head = mirror_links[cur];
                  mirror_links[cur] = mirror_free;
                  mirror_free       = cur;
                  if (mirror_count != 0) mirror_count--;
                  r.ok   = 1'b1;
                  r.slot = cur[SLOT_W-1:0];
               end
            end
            default: begin
               if (found) begin
                  r.ok   = 1'b1;
                  r.slot = cur[SLOT_W-1:0];
               end
            end
         endcase
      end
      r.count = mirror_count;
      return r;
   endfunction

   function automatic void note_failure(input string msg);
      if (fail_count < 10) $display("%s", msg);
      fail_count++;
   endfunction

   always @(posedge clock) begin
      table_rsp_type oldest;
      if (reset) begin
         foreach (mirror_keys[i]) mirror_keys[i] = '0;
         rebuild_free_list();
         predicted_rsps.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsps.size() == 0) begin
               note_failure($sformatf("unexpected rsp word: ok %0b slot %0d count %0d",
                                      rsp_ok, rsp_slot, rsp_count));
            end else begin
               oldest = predicted_rsps.pop_front();
               if (rsp_ok !== oldest.ok || rsp_slot !== oldest.slot ||
                   rsp_count !== oldest.count) begin
                  note_failure($sformatf({"rsp mismatch for cmd %0d key %0d: ",
                                          "expected ok %0b slot %0d count %0d, ",
                                          "got ok %0b slot %0d count %0d"},
                                         oldest.cmd, $signed(oldest.key),
                                         oldest.ok, oldest.slot, oldest.count,
                                         rsp_ok, rsp_slot, rsp_count));
               end
            end
         end
         if (req_valid && req_ready) begin
            predicted_rsps.push_back(apply_command(req_cmd, req_key));
         end
      end
      pending_count <= predicted_rsps.size();
   end

endmodule

@@ tb/sv/tb_sorted_linked_list_table_core.sv @@
// Testbench top for the sorted linked list table: clock, reset, stimulus, watchdog, verdict.
`timescale 1ns / 1ps
module tb_sorted_linked_list_table_core;
   import sllt_pkg::*;

   localparam int RANDOM_WORDS = 1150;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 80;

   logic        clock;
   logic        reset;
   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned quiet_cycles = 0;
   int unsigned ready_left = 0;
   bit          no_gaps;

   sllt_req_if req_chan ();
   sllt_rsp_if rsp_chan ();

   sorted_linked_list_table_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sllt_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_cmd       (req_chan.cmd),
      .req_key       (req_chan.key),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_ok        (rsp_chan.ok),
      .rsp_slot      (rsp_chan.slot),
      .rsp_count     (rsp_chan.count),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 96) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // narrow keys collide often; wide keys spread over the whole range
   function automatic logic signed [KEY_W-1:0] pick_key(input bit wide);
      int unsigned r;
      r = $urandom_range(0, 19);
      if (wide || r == 0) return $urandom;
      else if (r == 1) return 32'h8000_0000 + $urandom_range(0, 3);
      else if (r == 2) return 32'h7fff_ffff - $urandom_range(0, 3);
      else return $signed($urandom_range(0, 95)) - 48;
   endfunction

   task automatic send_word(input cmd_type cmd, input logic signed [KEY_W-1:0] key);
      int unsigned gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd   <= cmd;
      req_chan.key   <= key;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   // rsp side back-pressure
   always @(posedge clock) begin
      if (ready_left != 0) begin
         ready_left <= ready_left - 1;
      end else if (rsp_chan.ready) begin
         rsp_chan.ready <= 1'b0;
         ready_left     <= pick_gap();
      end else begin
         rsp_chan.ready <= 1'b1;
         ready_left     <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(0, 20);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_sorted_linked_list_table_core: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned             sent;
      int unsigned             kind;
      int unsigned             episode_len;
      int unsigned             r;
      cmd_type                 cmd;
      logic signed [KEY_W-1:0] key;

      req_chan.valid = 1'b0;
      req_chan.cmd   = CMD_INSERT;
      req_chan.key   = '0;
      rsp_chan.ready = 1'b0;
      reset          = 1'b1;
      no_gaps        = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, extremes, duplicates, head and tail removal, clear
      send_word(CMD_SEARCH, 0);
      send_word(CMD_DELETE, 5);
      send_word(CMD_INSERT, 0);
      send_word(CMD_INSERT, 32'sh8000_0000);
      send_word(CMD_INSERT, 32'sh7fff_ffff);
      send_word(CMD_INSERT, -1);
      send_word(CMD_INSERT, 0);
      send_word(CMD_INSERT, 32'sh7fff_ffff);
      send_word(CMD_SEARCH, 32'sh8000_0000);
      send_word(CMD_SEARCH, 32'sh7fff_ffff);
      send_word(CMD_SEARCH, 1);
      send_word(CMD_DELETE, 32'sh8000_0000);
      send_word(CMD_DELETE, 32'sh7fff_ffff);
      send_word(CMD_DELETE, 0);
      send_word(CMD_INSERT, 32'sh5555_5555);
      send_word(CMD_INSERT, 32'shaaaa_aaaa);
      send_word(CMD_SEARCH, 32'shaaaa_aaaa);
      send_word(CMD_CLEAR, 32'shffff_ffff);
      send_word(CMD_SEARCH, -1);
      send_word(CMD_INSERT, 7);
      send_word(CMD_DELETE, 7);
      send_word(CMD_INSERT, 8);

      // random episodes: fill toward full, churn, drain
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         kind        = $urandom_range(0, 99);
         no_gaps     = ($urandom_range(0, 3) == 0);
         episode_len = (kind < 30) ? $urandom_range(80, 120) : $urandom_range(30, 80);
         for (int i = 0; i < episode_len; i++) begin
            r = $urandom_range(0, 99);
            if (kind < 30) begin
               cmd = (r < 85) ? CMD_INSERT : (r < 93) ? CMD_SEARCH : CMD_DELETE;
               key = pick_key($urandom_range(0, 1));
            end else if (kind < 80) begin
               cmd = (r < 35) ? CMD_INSERT : (r < 70) ? CMD_DELETE : CMD_SEARCH;
               key = pick_key(r >= 95);
            end else begin
               cmd = (r < 70) ? CMD_DELETE : (r < 85) ? CMD_SEARCH : CMD_INSERT;
               key = pick_key(1'b0);
            end
            if ($urandom_range(0, 99) < 3) begin
               cmd = cmd_type'($urandom_range(0, 3));
               key = $urandom;
            end
            send_word(cmd, key);
            sent++;
         end
         if ($urandom_range(0, 9) < 4) begin
            send_word(CMD_CLEAR, $urandom);
            sent++;
         end
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_sorted_linked_list_table_core: PASS");
      end else begin
         $display("tb_sorted_linked_list_table_core: FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/sllt_pkg.sv
design/sllt_if.sv
design/sllt_store.sv
design/sorted_linked_list_table_core.sv
tb/sv/sllt_checker.sv
tb/sv/tb_sorted_linked_list_table_core.sv
